### hdl/indexed_sequence_store_defines.svh
// Assertion macros used by the checker file of the indexed sequence store.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/isq_pkg.sv
package isq_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_FRONT  = 3'd1,
        CMD_BACK   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD   = 2'd0,
        SHIFT_INSERT = 2'd1,
        SHIFT_DELETE = 2'd2
    } shift_op_t;

    typedef struct packed {
        shift_op_t         op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

### hdl/isq_cell.sv
module isq_cell #(
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  isq_pkg::cell_ctrl_t        ctrl,
    input  logic [isq_pkg::DATA_W-1:0] left_data,
    input  logic [isq_pkg::DATA_W-1:0] right_data,
    output logic [isq_pkg::DATA_W-1:0] data
);

    localparam logic [isq_pkg::POS_W-1:0] MyIndex = isq_pkg::POS_W'(INDEX);

    logic [isq_pkg::DATA_W-1:0] entry_reg;
    logic [isq_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            isq_pkg::SHIFT_INSERT:
            begin
                if (MyIndex == ctrl.pos)
                begin
                    entry_next = ctrl.value;
                end
                else if (MyIndex > ctrl.pos)
                begin
                    entry_next = left_data;
                end
            end
            isq_pkg::SHIFT_DELETE:
            begin
                if (MyIndex >= ctrl.pos)
                begin
                    entry_next = right_data;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

### hdl/indexed_sequence_store.sv
// Latency: a result appears in the cycle after its input transfer.
// Throughput: one item per cycle; cells from the target slot on update together.
// The input is stalled only while a finished result waits on a stalled output.
// Reset clears the element count and the output valid flag at once.
// The stored entries are not reset and are only read once written.
module indexed_sequence_store #(
    parameter int CAPACITY = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [isq_pkg::CMD_W-1:0]    command,
    input  logic [isq_pkg::POS_W-1:0]    position,
    input  logic [isq_pkg::DATA_W-1:0]   value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [isq_pkg::DATA_W-1:0]   read_data,
    output logic [isq_pkg::STATUS_W-1:0] status,
    output logic [isq_pkg::LEN_W-1:0]    length
);

    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int IdxW  = $clog2(CAPACITY);
    localparam int PosW  = isq_pkg::POS_W;
    localparam int CmpW  = (CntW > PosW) ? CntW : PosW;
    localparam int LenW  = isq_pkg::LEN_W;
    localparam int DataW = isq_pkg::DATA_W;

    localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

    logic [CntW-1:0]            count_reg;
    logic [CntW-1:0]            count_next;
    logic [CntW-1:0]            count_calc;
    logic                       out_valid_reg;
    logic [DataW-1:0]           read_data_reg;
    logic [isq_pkg::STATUS_W-1:0] status_reg;
    logic [LenW-1:0]            length_reg;

    logic                       accept;
    logic [CmpW-1:0]            pos_cmp;
    logic [CmpW-1:0]            cnt_cmp;
    logic                       full;
    logic [DataW-1:0]           res_data;
    isq_pkg::status_t           res_status;
    isq_pkg::cell_ctrl_t        ctrl_calc;
    isq_pkg::cell_ctrl_t        cell_ctrl;
    logic [DataW-1:0]           cell_data [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign pos_cmp  = CmpW'(position);
    assign cnt_cmp  = CmpW'(count_reg);
    assign full     = (count_reg == Full);

    always_comb
    begin
        res_data        = '0;
        res_status      = isq_pkg::ST_DONE;
        count_calc      = count_reg;
        ctrl_calc.op    = isq_pkg::SHIFT_HOLD;
        ctrl_calc.pos   = position;
        ctrl_calc.value = value;
        unique case (isq_pkg::cmd_t'(command))
            isq_pkg::CMD_READ:
            begin
                if (pos_cmp < cnt_cmp)
                begin
                    res_data = cell_data[position[IdxW-1:0]];
                end
                else
                begin
                    res_data   = isq_pkg::READ_MISS;
                    res_status = isq_pkg::ST_RANGE;
                end
            end
            isq_pkg::CMD_FRONT:
            begin
                if (full)
                begin
                    res_status = isq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl_calc.op  = isq_pkg::SHIFT_INSERT;
                    ctrl_calc.pos = '0;
                    count_calc    = count_reg + 1'b1;
                end
            end
            isq_pkg::CMD_BACK:
            begin
                if (full)
                begin
                    res_status = isq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl_calc.op  = isq_pkg::SHIFT_INSERT;
                    ctrl_calc.pos = PosW'(count_reg);
                    count_calc    = count_reg + 1'b1;
                end
            end
            isq_pkg::CMD_INSERT:
            begin
                if (pos_cmp > cnt_cmp)
                begin
                    res_status = isq_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    res_status = isq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl_calc.op = isq_pkg::SHIFT_INSERT;
                    count_calc   = count_reg + 1'b1;
                end
            end
            isq_pkg::CMD_DELETE:
            begin
                if (pos_cmp < cnt_cmp)
                begin
                    ctrl_calc.op = isq_pkg::SHIFT_DELETE;
                    count_calc   = count_reg - 1'b1;
                end
                else
                begin
                    res_status = isq_pkg::ST_RANGE;
                end
            end
            default:
            begin
                res_status = isq_pkg::ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl  = ctrl_calc;
        count_next = count_calc;
        if (!accept)
        begin
            cell_ctrl.op = isq_pkg::SHIFT_HOLD;
            count_next   = count_reg;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DataW-1:0] left_in;
        logic [DataW-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_data[i+1];
        end

        isq_cell #(
            .INDEX(i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= res_data;
            status_reg    <= res_status;
            length_reg    <= LenW'(count_calc);
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;
    assign length    = length_reg;

endmodule

### hdl/isq_checker.sv
`include "indexed_sequence_store_defines.svh"

module isq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [isq_pkg::DATA_W-1:0]   read_data,
    input logic [isq_pkg::STATUS_W-1:0] status,
    input logic [isq_pkg::LEN_W-1:0]    length
);

    localparam logic [isq_pkg::LEN_W-1:0] FullLen = isq_pkg::LEN_W'(CAPACITY);
    localparam int ResultW = isq_pkg::DATA_W + isq_pkg::STATUS_W + isq_pkg::LEN_W;

    logic               in_xfer;
    logic               out_held;
    logic               status_known;
    logic               full_res;
    logic               full_ok;
    logic               held_ok;
    logic [ResultW-1:0] result_word;
    logic [ResultW-1:0] prev_word_reg;

    assign in_xfer      = in_valid && !in_stall;
    assign out_held     = out_valid && out_stall;
    assign status_known = (status == isq_pkg::ST_DONE) || (status == isq_pkg::ST_RANGE)
                          || (status == isq_pkg::ST_FULL);
    assign full_res     = out_valid && (status == isq_pkg::ST_FULL);
    assign full_ok      = (read_data == '0) && (length == FullLen);
    assign result_word  = {read_data, status, length};
    assign held_ok      = out_valid && (result_word == prev_word_reg);

    always_ff @(posedge clk)
    begin
        prev_word_reg <= result_word;
    end

    `ISQ_ASSERT_NEXT(a_result_follows, clk, rst_n, in_xfer, out_valid, "missing result")
    `ISQ_ASSERT_NEXT(a_result_holds, clk, rst_n, out_held, held_ok, "stalled result changed")
    `ISQ_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, status_known, "unknown status code")
    `ISQ_ASSERT_SAME(a_full_result, clk, rst_n, full_res, full_ok, "bad full result")

endmodule

bind indexed_sequence_store isq_checker #(
    .CAPACITY(CAPACITY)
) u_isq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .status    (status),
    .length    (length)
);

### dv/indexed_sequence_store_check.sv
`timescale 1ns / 1ps

module indexed_sequence_store_check #(
    parameter int CAPACITY = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [isq_pkg::CMD_W-1:0]    command,
    input  logic [isq_pkg::POS_W-1:0]    position,
    input  logic [isq_pkg::DATA_W-1:0]   value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [isq_pkg::DATA_W-1:0]   read_data,
    input  logic [isq_pkg::STATUS_W-1:0] status,
    input  logic [isq_pkg::LEN_W-1:0]    length,
    output int                           mismatch_count,
    output int                           outstanding
);

    typedef struct packed {
        logic [isq_pkg::DATA_W-1:0] data;
        isq_pkg::status_t           st;
        logic [isq_pkg::LEN_W-1:0]  len;
    } outcome_t;

    logic [isq_pkg::DATA_W-1:0] stored [CAPACITY];
    int                         stored_len = 0;
    outcome_t                   pending_outcomes [$];
    int                         failures = 0;

    task automatic insert_entry(input int slot, input logic [isq_pkg::DATA_W-1:0] val);
        int i;
        for (i = stored_len; i > slot; i--)
        begin
            stored[i] = stored[i-1];
        end
        stored[slot] = val;
        stored_len++;
    endtask

    task automatic remove_entry(input int slot);
        int i;
        for (i = slot; i + 1 < stored_len; i++)
        begin
            stored[i] = stored[i+1];
        end
        stored_len--;
    endtask

    task automatic apply_command(input logic [isq_pkg::CMD_W-1:0] cmd,
                                 input logic [isq_pkg::POS_W-1:0] pos,
                                 input logic [isq_pkg::DATA_W-1:0] val,
                                 output outcome_t res);
        int slot;
        slot = int'(pos);
        res.data = '0;
        res.st = isq_pkg::ST_DONE;
        case (cmd)
            isq_pkg::CMD_READ:
            begin
                if (slot < stored_len)
                begin
                    res.data = stored[slot];
                end
                else
                begin
                    res.data = isq_pkg::READ_MISS;
                    res.st = isq_pkg::ST_RANGE;
                end
            end
            isq_pkg::CMD_FRONT, isq_pkg::CMD_BACK:
            begin
                if (stored_len >= CAPACITY)
                begin
                    res.st = isq_pkg::ST_FULL;
                end
                else
                begin
                    insert_entry((cmd == isq_pkg::CMD_FRONT) ? 0 : stored_len, val);
                end
            end
            isq_pkg::CMD_INSERT:
            begin
                if (slot > stored_len)
                begin
                    res.st = isq_pkg::ST_RANGE;
                end
                else if (stored_len >= CAPACITY)
                begin
                    res.st = isq_pkg::ST_FULL;
                end
                else
                begin
                    insert_entry(slot, val);
                end
            end
            isq_pkg::CMD_DELETE:
            begin
                if (slot < stored_len)
                begin
                    remove_entry(slot);
                end
                else
                begin
                    res.st = isq_pkg::ST_RANGE;
                end
            end
            default:
            begin
                res.st = isq_pkg::ST_RANGE;
            end
        endcase
        res.len = isq_pkg::LEN_W'(stored_len);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t predicted;
        outcome_t oldest;
        if (!rst_n)
        begin
            stored_len = 0;
            pending_outcomes.delete();
            mismatch_count <= failures;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_command(command, position, value, predicted);
                pending_outcomes.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("%0t: unexpected result: data %h status %0d length %0d",
                                 $time, read_data, status, length);
                    end
                end
                else
                begin
                    oldest = pending_outcomes.pop_front();
                    if (read_data !== oldest.data || status !== oldest.st
                        || length !== oldest.len)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("%0t: expected %h/%0d/%0d, got %h/%0d/%0d",
                                     $time, oldest.data, oldest.st, oldest.len,
                                     read_data, status, length);
                        end
                    end
                end
            end
            mismatch_count <= failures;
            outstanding <= pending_outcomes.size();
        end
    end

endmodule

### dv/indexed_sequence_store_test.sv
`timescale 1ns / 1ps

module indexed_sequence_store_test;

    localparam int CAPACITY = 16;
    localparam int RANDOM_ITEMS = 1520;
    localparam logic [isq_pkg::CMD_W-1:0] FIRST_UNUSED_CMD = 3'd5;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [isq_pkg::CMD_W-1:0]    command;
    logic [isq_pkg::POS_W-1:0]    position;
    logic [isq_pkg::DATA_W-1:0]   value;
    logic                         out_valid;
    logic                         out_stall;
    logic [isq_pkg::DATA_W-1:0]   read_data;
    logic [isq_pkg::STATUS_W-1:0] status;
    logic [isq_pkg::LEN_W-1:0]    length;
    int                           mismatch_count;
    int                           outstanding;

    int burst_left = 0;

    indexed_sequence_store #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .position(position),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .status(status),
        .length(length)
    );

    indexed_sequence_store_check #(
        .CAPACITY(CAPACITY)
    ) i_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .position(position),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .status(status),
        .length(length),
        .mismatch_count(mismatch_count),
        .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 2)
        begin
            burst_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // Offers one command, waits for the edge where the transfer takes place,
    // then idles the input for a random gap that may be zero.
    task automatic issue_command(input logic [isq_pkg::CMD_W-1:0] cmd,
                                 input logic [isq_pkg::POS_W-1:0] pos,
                                 input logic [isq_pkg::DATA_W-1:0] val);
        int gap;
        in_valid <= 1'b1;
        command <= cmd;
        position <= pos;
        value <= val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [isq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(19))
            0: return '0;
            1: return isq_pkg::READ_MISS;
            2: return {1'b1, {(isq_pkg::DATA_W-1){1'b0}}};
            3: return {1'b0, {(isq_pkg::DATA_W-1){1'b1}}};
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The receiver holds off once for a long stretch early in the random part,
    // then stalls at random.
    initial
    begin
        out_stall <= 1'b0;
        repeat (300) @(posedge clk);
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        forever
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(20, 1)) @(posedge clk);
                end
                4:
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(100, 40)) @(posedge clk);
                end
                5, 6, 7, 8:
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(3, 1)) @(posedge clk);
                end
                default:
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(40, 10)) @(posedge clk);
                end
            endcase
        end
    end

    initial
    begin
        int                        n;
        int                        r;
        int                        wait_cycles;
        bit                        growing;
        logic [isq_pkg::CMD_W-1:0] cmd;
        logic [isq_pkg::POS_W-1:0] pos;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        command <= isq_pkg::CMD_READ;
        position <= '0;
        value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_command(isq_pkg::CMD_READ, 8'd0, '0);
        issue_command(isq_pkg::CMD_DELETE, 8'd0, '0);
        issue_command(isq_pkg::CMD_INSERT, 8'd1, 32'h1234_5678);
        issue_command(isq_pkg::CMD_INSERT, 8'd0, 32'h8000_0000);
        issue_command(isq_pkg::CMD_FRONT, 8'd255, 32'h7FFF_FFFF);
        issue_command(isq_pkg::CMD_BACK, 8'd0, 32'hFFFF_FFFF);
        issue_command(isq_pkg::CMD_READ, 8'd2, '0);
        issue_command(isq_pkg::CMD_READ, 8'd255, 32'hFFFF_FFFF);
        for (n = 0; n < 3; n++)
        begin
            issue_command(FIRST_UNUSED_CMD + isq_pkg::CMD_W'(n), 8'd255, $urandom());
        end
        for (n = 0; n < 13; n++)
        begin
            issue_command((n % 2 == 0) ? isq_pkg::CMD_INSERT : isq_pkg::CMD_BACK,
                          isq_pkg::POS_W'(n / 2), $urandom());
        end
        issue_command(isq_pkg::CMD_BACK, 8'd0, 32'h0000_0001);
        issue_command(isq_pkg::CMD_FRONT, 8'd0, 32'h0000_0002);
        issue_command(isq_pkg::CMD_INSERT, 8'd16, 32'h0000_0003);
        issue_command(isq_pkg::CMD_INSERT, 8'd17, 32'h0000_0004);
        issue_command(isq_pkg::CMD_READ, 8'd15, '0);
        issue_command(isq_pkg::CMD_READ, 8'd16, '0);
        issue_command(isq_pkg::CMD_DELETE, 8'd15, '0);
        issue_command(isq_pkg::CMD_DELETE, 8'd0, '0);

        // Phases that mostly grow the sequence alternate with phases that mostly
        // shrink it, so that both the empty and the full store recur.
        growing = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(24) == 0)
            begin
                growing = !growing;
            end
            r = $urandom_range(99);
            if (r < 2)
            begin
                cmd = FIRST_UNUSED_CMD + isq_pkg::CMD_W'($urandom_range(2));
            end
            else if (r < 20)
            begin
                cmd = isq_pkg::CMD_READ;
            end
            else if (r < (growing ? 80 : 40))
            begin
                case ($urandom_range(2))
                    0: cmd = isq_pkg::CMD_FRONT;
                    1: cmd = isq_pkg::CMD_BACK;
                    default: cmd = isq_pkg::CMD_INSERT;
                endcase
            end
            else
            begin
                cmd = isq_pkg::CMD_DELETE;
            end
            if ($urandom_range(9) == 0)
            begin
                pos = isq_pkg::POS_W'($urandom_range(255));
            end
            else
            begin
                pos = isq_pkg::POS_W'($urandom_range(CAPACITY + 1));
            end
            issue_command(cmd, pos, pick_value());
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (5) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/isq_pkg.sv
hdl/isq_cell.sv
hdl/indexed_sequence_store.sv
hdl/isq_checker.sv
dv/indexed_sequence_store_check.sv
dv/indexed_sequence_store_test.sv
